>>> rtl/dtmf_pkg.sv
// Shared types, codes and micro-op table for the DTMF Goertzel detector.
package dtmf_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W    = 16;
  localparam int COEFF_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int COEFF_FRAC  = 14;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int STEP_W      = 4;
  localparam logic [STEP_W-1:0] POW_LAST_STEP = 4'd15;

  // Multiplier operand A selects.
  localparam logic [2:0] A_COEFF = 3'd0;
  localparam logic [2:0] A_Q1L   = 3'd1;
  localparam logic [2:0] A_Q1H   = 3'd2;
  localparam logic [2:0] A_Q2L   = 3'd3;
  localparam logic [2:0] A_Q2H   = 3'd4;
  localparam logic [2:0] A_V0    = 3'd5;
  localparam logic [2:0] A_V1    = 3'd6;
  localparam logic [2:0] A_V2    = 3'd7;

  // Multiplier operand B selects.
  localparam logic [1:0] B_Q1L = 2'd0;
  localparam logic [1:0] B_Q1H = 2'd1;
  localparam logic [1:0] B_Q2L = 2'd2;
  localparam logic [1:0] B_Q2H = 2'd3;

  // Accumulator operations.
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Left shifts applied to a product before accumulation.
  localparam logic [2:0] SH_0  = 3'd0;
  localparam logic [2:0] SH_14 = 3'd1;
  localparam logic [2:0] SH_32 = 3'd2;
  localparam logic [2:0] SH_46 = 3'd3;
  localparam logic [2:0] SH_64 = 3'd4;
  localparam logic [2:0] SH_78 = 3'd5;
  localparam logic [2:0] SH_96 = 3'd6;

  // Operations done on the finished accumulator value.
  localparam logic [1:0] POST_NONE  = 2'd0;
  localparam logic [1:0] POST_RES   = 2'd1;
  localparam logic [1:0] POST_VSAVE = 2'd2;
  localparam logic [1:0] POST_PICK  = 2'd3;

  // Input and result words.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } smp_t;

  typedef struct packed {
    logic [1:0] low_index;
    logic [1:0] high_index;
    logic       low_found;
    logic       high_found;
  } det_t;

  // One datapath micro-op.
  typedef struct packed {
    logic [2:0] a_sel;
    logic [1:0] b_sel;
    logic [1:0] acc_op;
    logic [2:0] shift_sel;
    logic       rnd;
    logic [1:0] post_op;
  } cmd_t;

  // Controller to datapath commands.
  typedef struct packed {
    cmd_t cmd;
    logic capture;
    logic load_result;
    logic clear_state;
  } ctl_t;

  localparam cmd_t CMD_IDLE = '{a_sel: A_COEFF, b_sel: B_Q1L, acc_op: ACC_NONE,
                                shift_sel: SH_0, rnd: 1'b0, post_op: POST_NONE};

  // Resonator update: coeff*q1 rounded, then the saturating tail.
  localparam cmd_t RES_HI_CMD = '{a_sel: A_COEFF, b_sel: B_Q1H, acc_op: ACC_LOAD,
                                  shift_sel: SH_32, rnd: 1'b0, post_op: POST_NONE};
  localparam cmd_t RES_LO_CMD = '{a_sel: A_COEFF, b_sel: B_Q1L, acc_op: ACC_ADD,
                                  shift_sel: SH_0, rnd: 1'b1, post_op: POST_RES};

  function automatic cmd_t mk_cmd(input logic [2:0] a, input logic [1:0] b,
                                  input logic [1:0] op, input logic [2:0] sh,
                                  input logic [1:0] post);
    cmd_t c;
    c.a_sel     = a;
    c.b_sel     = b;
    c.acc_op    = op;
    c.shift_sel = sh;
    c.rnd       = 1'b0;
    c.post_op   = post;
    return c;
  endfunction

  // Bin power 2^14*(q1^2+q2^2) - (c*q1)*q2 as sixteen limb products.
  function automatic cmd_t pow_cmd(input logic [STEP_W-1:0] step);
    cmd_t c;
    case (step)
      4'd0:    c = mk_cmd(A_COEFF, B_Q1H, ACC_LOAD, SH_32, POST_NONE);
      4'd1:    c = mk_cmd(A_COEFF, B_Q1L, ACC_ADD,  SH_0,  POST_VSAVE);
      4'd2:    c = mk_cmd(A_Q1L,   B_Q1L, ACC_LOAD, SH_14, POST_NONE);
      4'd3:    c = mk_cmd(A_Q1L,   B_Q1H, ACC_ADD,  SH_46, POST_NONE);
      4'd4:    c = mk_cmd(A_Q1H,   B_Q1L, ACC_ADD,  SH_46, POST_NONE);
      4'd5:    c = mk_cmd(A_Q1H,   B_Q1H, ACC_ADD,  SH_78, POST_NONE);
      4'd6:    c = mk_cmd(A_Q2L,   B_Q2L, ACC_ADD,  SH_14, POST_NONE);
      4'd7:    c = mk_cmd(A_Q2L,   B_Q2H, ACC_ADD,  SH_46, POST_NONE);
      4'd8:    c = mk_cmd(A_Q2H,   B_Q2L, ACC_ADD,  SH_46, POST_NONE);
      4'd9:    c = mk_cmd(A_Q2H,   B_Q2H, ACC_ADD,  SH_78, POST_NONE);
      4'd10:   c = mk_cmd(A_V0,    B_Q2L, ACC_SUB,  SH_0,  POST_NONE);
      4'd11:   c = mk_cmd(A_V0,    B_Q2H, ACC_SUB,  SH_32, POST_NONE);
      4'd12:   c = mk_cmd(A_V1,    B_Q2L, ACC_SUB,  SH_32, POST_NONE);
      4'd13:   c = mk_cmd(A_V1,    B_Q2H, ACC_SUB,  SH_64, POST_NONE);
      4'd14:   c = mk_cmd(A_V2,    B_Q2L, ACC_SUB,  SH_64, POST_NONE);
      4'd15:   c = mk_cmd(A_V2,    B_Q2H, ACC_SUB,  SH_96, POST_PICK);
      default: c = CMD_IDLE;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/dtmf_dp.sv
// Datapath: coefficients, resonator state, shared multiplier, accumulator and picker.
module dtmf_dp import dtmf_pkg::*; #(
  parameter int TONES_PER_GROUP = 4,
  parameter int STATE_WIDTH     = 48,
  localparam int BINS  = 2 * TONES_PER_GROUP,
  localparam int BIN_W = $clog2(BINS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  input  logic [BIN_W-1:0]       bin,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]     cfg_data,
  input  smp_t                   smp_word,
  output det_t                   det_word
);

  localparam int SW    = STATE_WIDTH;
  localparam int ACC_W = 2 * SW + 16;
  localparam int V_W   = SW + 16;
  localparam int IDX_W = (BIN_W > 2) ? BIN_W : 2;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  // Architectural state.
  logic signed [COEFF_W-1:0]  coeff [BINS];
  logic signed [SW-1:0]       q1 [BINS];
  logic signed [SW-1:0]       q2 [BINS];
  logic signed [SAMPLE_W-1:0] x;

  // Pipeline registers.
  logic signed [PROD_W-1:0] prod;
  cmd_t                     s1_cmd;
  logic [BIN_W-1:0]         s1_bin, s2_bin, s3_bin;
  logic signed [SW-1:0]     s1_q1, s1_q2, s2_q1, s2_q2, s3_q1;
  logic [1:0]               s2_post;
  logic                     s3_res;
  logic signed [ACC_W-1:0]  acc;
  logic signed [V_W-1:0]    v;
  logic signed [SW:0]       diff;
  logic signed [ACC_W-1:0]  best;
  logic [1:0]               lo_idx, hi_idx;
  logic                     lo_found, hi_found;

  // Combinational signals.
  logic signed [COEFF_W-1:0] c_rd;
  logic signed [SW-1:0]      q1_rd, q2_rd;
  logic signed [63:0]        q1_64, q2_64;
  logic signed [95:0]        v_96;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]   pext, term, rnd_add, acc_next;
  logic [ACC_W-SW-14:0]      acc_top;
  logic                      acc_in_rng;
  logic signed [SW-1:0]      r_sat, d_sat, q0;
  logic signed [SW:0]        diff_next, sum;
  logic                      is_high, first, greater;
  logic [IDX_W-1:0]          tone_pos;
  logic signed [ACC_W-1:0]   best_cmp;
  logic [BIN_W-1:0]          cfg_addr;
  logic                      cfg_ok;

  // Coefficient write address: index bits [2] pick the group, [1:0] the bin.
  always_comb begin
    cfg_addr = BIN_W'(int'(cfg_index[2]) * TONES_PER_GROUP + int'(cfg_index[1:0]));
    cfg_ok   = int'(cfg_index[1:0]) < TONES_PER_GROUP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BINS; i++) coeff[i] <= '0;
    end else if (cfg_write && cfg_ok) begin
      coeff[cfg_addr] <= cfg_data;
    end
  end

  // Operand fetch for the bin being issued.
  always_comb begin
    c_rd  = coeff[bin];
    q1_rd = q1[bin];
    q2_rd = q2[bin];
    q1_64 = 64'(q1_rd);
    q2_64 = 64'(q2_rd);
    v_96  = 96'(v);
  end

  always_comb begin
    case (ctl.cmd.a_sel)
      A_COEFF: mul_a = MUL_W'(c_rd);
      A_Q1L:   mul_a = $signed({1'b0, q1_64[31:0]});
      A_Q1H:   mul_a = MUL_W'($signed(q1_64[63:32]));
      A_Q2L:   mul_a = $signed({1'b0, q2_64[31:0]});
      A_Q2H:   mul_a = MUL_W'($signed(q2_64[63:32]));
      A_V0:    mul_a = $signed({1'b0, v_96[31:0]});
      A_V1:    mul_a = $signed({1'b0, v_96[63:32]});
      A_V2:    mul_a = MUL_W'($signed(v_96[95:64]));
      default: mul_a = '0;
    endcase
    case (ctl.cmd.b_sel)
      B_Q1L:   mul_b = $signed({1'b0, q1_64[31:0]});
      B_Q1H:   mul_b = MUL_W'($signed(q1_64[63:32]));
      B_Q2L:   mul_b = $signed({1'b0, q2_64[31:0]});
      B_Q2H:   mul_b = MUL_W'($signed(q2_64[63:32]));
      default: mul_b = '0;
    endcase
  end

  // Accumulate stage: shifted product into the wide accumulator.
  always_comb begin
    pext = ACC_W'(prod);
    case (s1_cmd.shift_sel)
      SH_0:    term = pext;
      SH_14:   term = pext << 14;
      SH_32:   term = pext << 32;
      SH_46:   term = pext << 46;
      SH_64:   term = pext << 64;
      SH_78:   term = pext << 78;
      SH_96:   term = pext << 96;
      default: term = pext;
    endcase
    rnd_add = s1_cmd.rnd ? ACC_W'(2 ** (COEFF_FRAC - 1)) : '0;
    case (s1_cmd.acc_op)
      ACC_LOAD: acc_next = term + rnd_add;
      ACC_ADD:  acc_next = acc + term + rnd_add;
      ACC_SUB:  acc_next = acc - term;
      default:  acc_next = acc;
    endcase
  end

  // Post stage: round-and-saturate of coeff*q1, less q2.
  always_comb begin
    acc_top    = acc[ACC_W-1:SW+13];
    acc_in_rng = (&acc_top) || (~|acc_top);
    if (acc_in_rng) begin
      r_sat = acc[SW+13:14];
    end else begin
      r_sat = acc[ACC_W-1] ? SMIN : SMAX;
    end
    diff_next = (SW+1)'(r_sat) - (SW+1)'(s2_q2);
  end

  // Post stage: running maximum over the bins of one group.
  always_comb begin
    is_high  = s2_bin >= BIN_W'(TONES_PER_GROUP);
    tone_pos = IDX_W'(s2_bin) - (is_high ? IDX_W'(TONES_PER_GROUP) : '0);
    first    = tone_pos == '0;
    best_cmp = first ? '0 : best;
    greater  = acc > best_cmp;
  end

  // Write-back stage: saturate the difference, add the scaled sample, saturate.
  always_comb begin
    if (diff[SW] == diff[SW-1]) begin
      d_sat = diff[SW-1:0];
    end else begin
      d_sat = diff[SW] ? SMIN : SMAX;
    end
    sum = (SW+1)'(d_sat) + ((SW+1)'(x) <<< COEFF_FRAC);
    if (sum[SW] == sum[SW-1]) begin
      q0 = sum[SW-1:0];
    end else begin
      q0 = sum[SW] ? SMIN : SMAX;
    end
  end

  // Pipeline control bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cmd  <= CMD_IDLE;
      s2_post <= POST_NONE;
      s3_res  <= 1'b0;
    end else begin
      s1_cmd  <= ctl.cmd;
      s2_post <= s1_cmd.post_op;
      s3_res  <= s2_post == POST_RES;
    end
  end

  // Pipeline payload and arithmetic registers.
  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
    s1_bin <= bin;
    s1_q1  <= q1_rd;
    s1_q2  <= q2_rd;
    s2_bin <= s1_bin;
    s2_q1  <= s1_q1;
    s2_q2  <= s1_q2;
    s3_bin <= s2_bin;
    s3_q1  <= s2_q1;
    acc    <= acc_next;
    if (ctl.capture) x <= smp_word.sample;
    if (s2_post == POST_RES) diff <= diff_next;
    if (s2_post == POST_VSAVE) v <= acc[V_W-1:0];
    if (s2_post == POST_PICK) begin
      best <= greater ? acc : best_cmp;
      if (is_high) begin
        hi_idx   <= greater ? tone_pos[1:0] : (first ? 2'b00 : hi_idx);
        hi_found <= greater || (!first && hi_found);
      end else begin
        lo_idx   <= greater ? tone_pos[1:0] : (first ? 2'b00 : lo_idx);
        lo_found <= greater || (!first && lo_found);
      end
    end
    if (ctl.load_result) begin
      det_word.low_index  <= lo_idx;
      det_word.high_index <= hi_idx;
      det_word.low_found  <= lo_found;
      det_word.high_found <= hi_found;
    end
  end

  // Resonator state: written back per bin, cleared at the end of a block.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_state) begin
      for (int i = 0; i < BINS; i++) begin
        q1[i] <= '0;
        q2[i] <= '0;
      end
    end else if (s3_res) begin
      q1[s3_bin] <= q0;
      q2[s3_bin] <= s3_q1;
    end
  end

endmodule

>>> rtl/dtmf_ctrl.sv
// Controller: sample handshake, block counting and micro-op sequencing.
module dtmf_ctrl import dtmf_pkg::*; #(
  parameter int TONES_PER_GROUP = 4,
  parameter int MAX_BLOCK       = 4096,
  localparam int BINS  = 2 * TONES_PER_GROUP,
  localparam int BIN_W = $clog2(BINS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             smp_valid,
  output logic             smp_stall,
  input  logic             last_sample,
  output logic             det_valid,
  input  logic             det_stall,
  output ctl_t             ctl,
  output logic [BIN_W-1:0] bin
);

  localparam int CNT_W = $clog2(MAX_BLOCK);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RES      = 3'd1;
  localparam logic [2:0] ST_RES_WAIT = 3'd2;
  localparam logic [2:0] ST_POW      = 3'd3;
  localparam logic [2:0] ST_POW_WAIT = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  // Cycles to let the datapath pipeline empty after the last micro-op.
  localparam logic [1:0] RES_DRAIN = 2'd2;
  localparam logic [1:0] POW_DRAIN = 2'd1;

  logic [2:0]        state;
  logic [BIN_W-1:0]  bin_cnt;
  logic [STEP_W-1:0] step;
  logic [1:0]        drain;
  logic [CNT_W-1:0]  blk_cnt;
  logic              blk_end;
  logic              accept;
  logic              ends_block;
  logic              last_bin;
  logic              det_free;

  always_comb begin
    smp_stall  = rst || (state != ST_IDLE);
    accept     = smp_valid && !smp_stall;
    ends_block = last_sample || (blk_cnt == CNT_W'(MAX_BLOCK - 1));
    last_bin   = bin_cnt == BIN_W'(BINS - 1);
    det_free   = !det_valid || !det_stall;
    bin        = bin_cnt;
  end

  // Commands to the datapath.
  always_comb begin
    ctl.capture     = accept;
    ctl.load_result = (state == ST_DONE) && det_free;
    ctl.clear_state = (state == ST_DONE) && det_free;
    case (state)
      ST_RES:  ctl.cmd = step[0] ? RES_LO_CMD : RES_HI_CMD;
      ST_POW:  ctl.cmd = pow_cmd(step);
      default: ctl.cmd = CMD_IDLE;
    endcase
  end

  // Result valid: set when a new word is loaded, cleared when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      det_valid <= 1'b0;
    end else if ((state == ST_DONE) && det_free) begin
      det_valid <= 1'b1;
    end else if (det_valid && !det_stall) begin
      det_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bin_cnt   <= '0;
      step      <= '0;
      drain     <= '0;
      blk_cnt   <= '0;
      blk_end   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            blk_end <= ends_block;
            blk_cnt <= ends_block ? '0 : blk_cnt + CNT_W'(1);
            bin_cnt <= '0;
            step    <= '0;
            state   <= ST_RES;
          end
        end
        ST_RES: begin
          step <= {{(STEP_W-1){1'b0}}, ~step[0]};
          if (step[0]) begin
            if (last_bin) begin
              drain <= '0;
              state <= ST_RES_WAIT;
            end else begin
              bin_cnt <= bin_cnt + BIN_W'(1);
            end
          end
        end
        ST_RES_WAIT: begin
          if (drain == RES_DRAIN) begin
            bin_cnt <= '0;
            step    <= '0;
            state   <= blk_end ? ST_POW : ST_IDLE;
          end else begin
            drain <= drain + 2'd1;
          end
        end
        ST_POW: begin
          step <= step + STEP_W'(1);
          if (step == POW_LAST_STEP) begin
            if (last_bin) begin
              drain <= '0;
              state <= ST_POW_WAIT;
            end else begin
              bin_cnt <= bin_cnt + BIN_W'(1);
            end
          end
        end
        ST_POW_WAIT: begin
          if (drain == POW_DRAIN) begin
            state <= ST_DONE;
          end else begin
            drain <= drain + 2'd1;
          end
        end
        ST_DONE: begin
          if (det_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/dtmf_goertzel_detector_core.sv
// Top level of the DTMF Goertzel detector: controller plus datapath.
//
//   channel  direction  handshake            word
//   cfg      in         cfg_write            cfg_index, cfg_data (coefficient write)
//   smp      in         smp_valid/smp_stall  smp_word (sample, last_sample)
//   det      out        det_valid/det_stall  det_word (indexes and found flags)
//
// A sample word that does not end a block takes two passes per resonator through
// the shared 33x33 multiplier. A block-ending word adds the bin powers, sixteen
// limb products per bin through the same multiplier.
// Reset is synchronous and clears coefficients and resonator state at once.
// A stalled result word holds in its register while later samples are taken.
module dtmf_goertzel_detector_core import dtmf_pkg::*; #(
  parameter int TONES_PER_GROUP = 4,
  parameter int STATE_WIDTH     = 48,
  parameter int MAX_BLOCK       = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]     cfg_data,
  input  logic                   smp_valid,
  output logic                   smp_stall,
  input  smp_t                   smp_word,
  output logic                   det_valid,
  input  logic                   det_stall,
  output det_t                   det_word
);

  localparam int BIN_W = $clog2(2 * TONES_PER_GROUP);

  ctl_t             ctl;
  logic [BIN_W-1:0] bin;

  // Sequencer.
  dtmf_ctrl #(
    .TONES_PER_GROUP(TONES_PER_GROUP),
    .MAX_BLOCK      (MAX_BLOCK)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .smp_valid  (smp_valid),
    .smp_stall  (smp_stall),
    .last_sample(smp_word.last_sample),
    .det_valid  (det_valid),
    .det_stall  (det_stall),
    .ctl        (ctl),
    .bin        (bin)
  );

  // Arithmetic.
  dtmf_dp #(
    .TONES_PER_GROUP(TONES_PER_GROUP),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .bin      (bin),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .smp_word (smp_word),
    .det_word (det_word)
  );

endmodule
